### sv/b85d_pkg.sv
// Package for the base85 little-endian decoder.
// Holds the beat types, the queue entry type and the digit lookup functions.
// No dependencies; every module of the block imports it.
package b85d_pkg;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);
   localparam int GROUP_DIGITS = 5;
   localparam int CNT_WIDTH    = 3;
   localparam int NRES_WIDTH   = 3;
   localparam int BYTES_PER_GROUP = 4;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_TAB     = 8'h09;
   localparam logic [6:0] NOT_DIGIT    = 7'd85;

   typedef struct packed {
      logic [7:0] char_code;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       run_last;
      logic       message_end;
   } rsp_type;

   // One classified character on its way from the front to the back.
   typedef struct packed {
      logic [31:0]           term;       // digit times its place weight
      logic [NRES_WIDTH-1:0] nres;       // result beats this entry causes
      logic                  byte_valid; // 0 for the empty end marker and for entries that only add a digit
      logic                  is_last;
      logic                  clear;      // accumulator restarts afterwards
   } op_type;

   // Maps a 7-bit character onto its digit, or NOT_DIGIT.
   function automatic logic [6:0] digit_of(input logic [6:0] ch);
      logic [6:0] d;
      d = NOT_DIGIT;
      if (ch >= 7'h30 && ch <= 7'h39) begin
         d = ch - 7'h30;
      end else if (ch >= 7'h41 && ch <= 7'h5A) begin
         d = ch - 7'h41 + 7'd10;
      end else if (ch >= 7'h61 && ch <= 7'h7A) begin
         d = ch - 7'h61 + 7'd36;
      end else begin
         case (ch)
            7'h24:   d = 7'd62;
            7'h25:   d = 7'd63;
            7'h26:   d = 7'd64;
            7'h28:   d = 7'd65;
            7'h29:   d = 7'd66;
            7'h2A:   d = 7'd67;
            7'h2B:   d = 7'd68;
            7'h2D:   d = 7'd69;
            7'h3A:   d = 7'd70;
            7'h3B:   d = 7'd71;
            7'h3C:   d = 7'd72;
            7'h3D:   d = 7'd73;
            7'h3E:   d = 7'd74;
            7'h40:   d = 7'd75;
            7'h5B:   d = 7'd76;
            7'h5D:   d = 7'd77;
            7'h5E:   d = 7'd78;
            7'h5F:   d = 7'd79;
            7'h60:   d = 7'd80;
            7'h7B:   d = 7'd81;
            7'h7C:   d = 7'd82;
            7'h7D:   d = 7'd83;
            7'h7E:   d = 7'd84;
            default: d = NOT_DIGIT;
         endcase
      end
      return d;
   endfunction

   // Place weight 85^position for positions 0 to 4.
   function automatic logic [25:0] weight_of(input logic [CNT_WIDTH-1:0] pos);
      logic [25:0] w;
      case (pos)
         3'd0:    w = 26'd1;
         3'd1:    w = 26'd85;
         3'd2:    w = 26'd7225;
         3'd3:    w = 26'd614125;
         3'd4:    w = 26'd52200625;
         default: w = 26'd0;
      endcase
      return w;
   endfunction

endpackage

### sv/b85d_front.sv
// Front end of the base85 decoder: accepts characters, skips blanks and
// non-alphabet codes, weights each digit and decides what the back must emit.
// Depends on b85d_pkg.
module b85d_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  b85d_pkg::req_type  req_data,
   input  logic               q_full,
   output logic               push,
   output b85d_pkg::op_type   push_op
);
   import b85d_pkg::*;

   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 accept;
   logic                 is_blank;
   logic [6:0]           digit;
   logic                 is_digit;
   logic [CNT_WIDTH-1:0] count_after;
   logic                 group_done;
   logic [32:0]          product;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      is_blank = (req_data.char_code == CHAR_SPACE) ||
                 (req_data.char_code == CHAR_NEWLINE) ||
                 (req_data.char_code == CHAR_TAB);
      digit    = digit_of(req_data.char_code[6:0]);
      is_digit = !is_blank && (digit != NOT_DIGIT);
      product  = {7'd0, weight_of(count_ff)} * {26'd0, digit};

      count_after = is_digit ? count_ff + CNT_WIDTH'(1) : count_ff;
      group_done  = (count_after == CNT_WIDTH'(GROUP_DIGITS));

      push_op.term       = is_digit ? product[31:0] : 32'd0;
      push_op.is_last    = req_data.is_last;
      push_op.clear      = group_done || req_data.is_last;
      push_op.byte_valid = group_done || (req_data.is_last && count_after > CNT_WIDTH'(1));
      if (group_done) begin
         push_op.nres = NRES_WIDTH'(BYTES_PER_GROUP);
      end else if (req_data.is_last) begin
         // A partial group of n digits gives n-1 bytes; one digit or none gives the end marker.
         push_op.nres = (count_after > CNT_WIDTH'(1)) ?
                        NRES_WIDTH'(count_after - CNT_WIDTH'(1)) : NRES_WIDTH'(1);
      end else begin
         push_op.nres = '0;
      end

      push     = accept && (is_digit || req_data.is_last);
      count_in = count_ff;
      if (accept) begin
         count_in = push_op.clear ? '0 : count_after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### sv/b85d_queue.sv
// Short queue of classified characters between the front and the back end.
// Entries sit in flip-flops; the head is presented without a read delay.
// Depends on b85d_pkg.
module b85d_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b85d_pkg::op_type  push_op,
   output logic              full,
   output logic              head_valid,
   output b85d_pkg::op_type  head_op,
   input  logic              pop
);
   import b85d_pkg::*;

   op_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0] fill_ff, fill_in;
   logic                  do_pop;

   assign full       = (fill_ff == QCNT_WIDTH'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_op    = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = push   ? wr_ptr_ff + QPTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_WIDTH'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !do_pop) begin
         fill_in = fill_ff + QCNT_WIDTH'(1);
      end else if (!push && do_pop) begin
         fill_in = fill_ff - QCNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

### sv/b85d_back.sv
// Back end of the base85 decoder: sums weighted digits into the group word
// and sends the bytes of finished or flushed groups one beat at a time.
// Depends on b85d_pkg.
module b85d_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  b85d_pkg::op_type  head_op,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output b85d_pkg::rsp_type rsp_data
);
   import b85d_pkg::*;

   logic [31:0]           accum_ff, accum_in;
   logic [31:0]           word_ff, word_in;
   logic [NRES_WIDTH-1:0] rem_ff, rem_in;
   logic                  busy_ff, busy_in;
   logic                  bval_ff, bval_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  out_free;
   logic                  emit;
   logic                  finishing;
   logic [31:0]           sum;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      emit      = busy_ff && out_free;
      finishing = emit && (rem_ff == NRES_WIDTH'(1));
      // Entries that only add a digit never wait for the byte sender.
      pop       = head_valid && ((head_op.nres == '0) || !busy_ff || finishing);
      sum       = accum_ff + head_op.term;

      accum_in     = accum_ff;
      word_in      = word_ff;
      rem_in       = rem_ff;
      busy_in      = busy_ff;
      bval_in      = bval_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (emit) begin
         rsp_valid_in            = 1'b1;
         rsp_data_in.data_byte   = bval_ff ? word_ff[7:0] : 8'd0;
         rsp_data_in.byte_valid  = bval_ff;
         rsp_data_in.run_last    = (rem_ff == NRES_WIDTH'(1));
         rsp_data_in.message_end = (rem_ff == NRES_WIDTH'(1)) && last_ff;
         word_in                 = {8'd0, word_ff[31:8]};
         rem_in                  = rem_ff - NRES_WIDTH'(1);
         busy_in                 = (rem_ff != NRES_WIDTH'(1));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (pop) begin
         accum_in = head_op.clear ? 32'd0 : sum;
         if (head_op.nres != '0) begin
            word_in = sum;
            rem_in  = head_op.nres;
            busy_in = 1'b1;
            bval_in = head_op.byte_valid;
            last_in = head_op.is_last;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rem_ff      <= rem_in;
      bval_ff     <= bval_in;
      last_ff     <= last_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         accum_ff     <= accum_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### sv/base85_little_endian_decoder.sv
// Base85 decoder, digits least significant first, one character per beat.
// Top level; instantiates b85d_front, b85d_queue and b85d_back and imports b85d_pkg.
//
// Usage:
//   The req channel carries one character per beat (char_code, is_last).
//   Blanks and non-alphabet characters are dropped; bit 7 is ignored. Every fifth digit
//   completes a group that leaves on the rsp channel as four byte beats,
//   least significant first. The beat marked is_last flushes a partial group
//   of n digits as n-1 bytes, or gives one beat with byte_valid low; its
//   final beat carries message_end. run_last marks the last rsp beat caused
//   by one req beat.
//   Throughput: one req beat per cycle while the four-entry queue has room.
//   The back end sends one rsp beat per cycle while the receiver is ready,
//   so a group holds the output port for four beats; the queue absorbs the input of the next group.
//   Path: a completing character's first byte passes through the queue
//   entry, written at the accepting edge, then the group word register,
//   then the output register.
//   Reset clears the digit counter, the queue and the accumulator; nothing
//   is in flight afterwards. When the receiver stalls, the output register
//   holds its beat, the queue fills and req_ready falls.
module base85_little_endian_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  b85d_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output b85d_pkg::rsp_type  rsp_data
);
   import b85d_pkg::*;

   logic   q_full;
   logic   push;
   op_type push_op;
   logic   head_valid;
   op_type head_op;
   logic   pop;

   b85d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_op   (push_op)
   );

   b85d_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_op    (push_op),
      .full       (q_full),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop)
   );

   b85d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_op    (head_op),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### tb/sv/b85d_stream_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the base85 little-endian decoder: watches both channels,
// predicts the byte beats of every accepted character and compares them.
// Depends on b85d_pkg for the beat types and the blank character codes.
module b85d_stream_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  b85d_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  b85d_pkg::rsp_type rsp_data,
   output int                error_count,
   output int                pending_beats
);

   import b85d_pkg::*;

   logic [6:0]  digit_map [128];
   logic [31:0] group_word;
   int          group_digits;
   rsp_type     expected_beats [$];

   initial begin
      string       low_digits;
      string       high_digits;
      logic [7:0]  c;
      low_digits  = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz$%&()*+-:;<=>@[]^_";
      high_digits = "{|}~";
      error_count   = 0;
      pending_beats = 0;
      group_word    = '0;
      group_digits  = 0;
      for (int i = 0; i < 128; i++) begin
         digit_map[i] = NOT_DIGIT;
      end
      for (int i = 0; i < low_digits.len(); i++) begin
         c = low_digits[i];
         digit_map[c[6:0]] = 7'(i);
      end
      // The backquote sits between the two runs of the alphabet.
      digit_map[7'h60] = 7'd80;
      for (int i = 0; i < high_digits.len(); i++) begin
         c = high_digits[i];
         digit_map[c[6:0]] = 7'(81 + i);
      end
   end

   task automatic report_mismatch(input string msg);
      $display("%0t: b85d_stream_checker: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      end
   endtask

   function automatic rsp_type make_beat(input logic [7:0] value, input logic carries);
      rsp_type beat;
      beat.data_byte   = value;
      beat.byte_valid  = carries;
      beat.run_last    = 1'b0;
      beat.message_end = 1'b0;
      return beat;
   endfunction

   task automatic predict_beats(input req_type item);
      logic [6:0]  digit;
      logic [31:0] place;
      logic [31:0] tail_word;
      int          produced;
      int          keep;
      rsp_type     beats [4];
      produced = 0;
      if (item.char_code != CHAR_SPACE && item.char_code != CHAR_NEWLINE &&
          item.char_code != CHAR_TAB) begin
         digit = digit_map[item.char_code[6:0]];
         if (digit != NOT_DIGIT) begin
            place = 32'd1;
            for (int k = 0; k < group_digits; k++) begin
               place = place * 32'd85;
            end
            // The sum wraps at 32 bits, as a group of large digits overflows.
            group_word = group_word + place * {25'd0, digit};
            group_digits++;
            if (group_digits == 5) begin
               for (int k = 0; k < 4; k++) begin
                  beats[produced] = make_beat(group_word[8*k +: 8], 1'b1);
                  produced++;
               end
               group_word   = '0;
               group_digits = 0;
            end
         end
      end
      if (item.is_last) begin
         keep      = (group_digits > 1) ? group_digits - 1 : 0;
         tail_word = group_word;
         for (int k = 0; k < keep && produced < 4; k++) begin
            beats[produced] = make_beat(tail_word[7:0], 1'b1);
            produced++;
            tail_word = tail_word >> 8;
         end
         if (produced == 0) begin
            beats[produced] = make_beat(8'h00, 1'b0);
            produced++;
         end
         beats[produced-1].message_end = 1'b1;
         group_word   = '0;
         group_digits = 0;
      end
      if (produced > 0) begin
         beats[produced-1].run_last = 1'b1;
      end
      for (int k = 0; k < produced; k++) begin
         expected_beats.push_back(beats[k]);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         group_word   = '0;
         group_digits = 0;
         expected_beats.delete();
      end else begin
         if (req_valid && req_ready) begin
            predict_beats(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch($sformatf("beat %0h arrived with nothing expected",
                                         rsp_data));
            end else begin
               want = expected_beats.pop_front();
               check_field("data_byte", rsp_data.data_byte, want.data_byte);
               check_field("byte_valid", 8'(rsp_data.byte_valid), 8'(want.byte_valid));
               check_field("run_last", 8'(rsp_data.run_last), 8'(want.run_last));
               check_field("message_end", 8'(rsp_data.message_end),
                           8'(want.message_end));
            end
         end
      end
      pending_beats <= expected_beats.size();
   end

endmodule

### tb/sv/base85_little_endian_decoder_test.sv
`timescale 1ns / 100ps
// Top of the base85 decoder testbench: clock, reset, character stimulus and verdict.
// Depends on b85d_pkg, the base85_little_endian_decoder RTL and b85d_stream_checker.
module base85_little_endian_decoder_test;

   import b85d_pkg::*;

   localparam int CLOCK_PERIOD = 8;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      error_count;
   int      pending_beats;

   int      send_idle_pct = 9;
   int      recv_idle_pct = 68;
   int      message_items;
   string   digit_chars =
      "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz$%&()*+-:;<=>@[]^_{|}~";

   base85_little_endian_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   b85d_stream_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_beats (pending_beats)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      #1_600_000;
      $display("base85_little_endian_decoder_test: done, errors");
      $finish;
   end

   // Holds the beat until it is taken; a random gap may come first.
   task automatic send_char(input logic [7:0] code, input logic last);
      req_type item;
      item.char_code = code;
      item.is_last   = last;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_text(input string text, input logic last);
      for (int i = 0; i < text.len(); i++) begin
         send_char(text[i], last && (i == text.len() - 1));
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] random_blank();
      case ($urandom_range(2))
         0:       return CHAR_SPACE;
         1:       return CHAR_NEWLINE;
         default: return CHAR_TAB;
      endcase
   endfunction

   function automatic logic [7:0] random_digit_char();
      int pick;
      pick = $urandom_range(84);
      if (pick == 84) begin
         return 8'h60;
      end
      return digit_chars[pick];
   endfunction

   // A well-formed message: digits with scattered blanks, closed by a last beat.
   task automatic send_message();
      int         len;
      logic       trailing;
      logic [7:0] code;
      len      = $urandom_range(1, 23);
      trailing = ($urandom_range(3) == 0);
      for (int k = 0; k < len; k++) begin
         if ($urandom_range(7) == 0) begin
            send_char(random_blank(), 1'b0);
         end
         code = random_digit_char();
         if ($urandom_range(7) == 0) begin
            code[7] = 1'b1;
         end
         send_char(code, (k == len - 1) && !trailing);
         message_items++;
      end
      if (trailing) begin
         send_char(random_blank(), 1'b1);
         message_items++;
      end
   endtask

   task automatic send_noise();
      int count;
      count = $urandom_range(1, 4);
      repeat (count) begin
         send_char(8'($urandom_range(255)), $urandom_range(9) == 0);
      end
   endtask

   task automatic run_random(input int target);
      message_items = 0;
      while (message_items < target) begin
         if ($urandom_range(9) < 8) begin
            send_message();
         end else begin
            send_noise();
         end
         if ($urandom_range(29) == 0) begin
            wait_drained();
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Largest group, with a high-bit alias of the top digit; the sum wraps.
      send_text("~~", 1'b0);
      send_char(8'hFE, 1'b0);
      send_text("~~", 1'b0);
      // Zero group broken up by every blank, closed by a high-bit zero.
      send_text("0 0", 1'b0);
      send_char(CHAR_NEWLINE, 1'b0);
      send_text("0", 1'b0);
      send_char(CHAR_TAB, 1'b0);
      send_text("0", 1'b0);
      send_char(8'hB0, 1'b0);
      // Characters outside the alphabet, including a space with bit 7 set.
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'hA0, 1'b0);
      // A lone digit at the end is dropped; a lone blank gives the end marker.
      send_text("A", 1'b1);
      send_text(" ", 1'b1);
      send_text("z$", 1'b0);
      send_char(8'h60, 1'b1);
      send_text("9@", 1'b1);
      // The last beat completes a full group.
      send_text("^_[];", 1'b1);
      wait_drained();

      run_random(80);
      send_idle_pct = 68;
      recv_idle_pct = 9;
      run_random(90);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(90);

      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_beats == 0) begin
         $display("base85_little_endian_decoder_test: done, clean");
      end else begin
         $display("base85_little_endian_decoder_test: done, errors");
      end
      $finish;
   end

endmodule
